/* rtl/weo_pkg.sv */
// ============================================================================
// weo_pkg: shared types and constants for the wheel encoder odometry block
// Widths, fixed-point constants, port widths and register indexes.
// ============================================================================
package weo_pkg;

	// Divider datapath widths.
	localparam int DIVN_W = 40;              // dividend
	localparam int DIVD_W = 24;              // divisor
	localparam int QUO_W  = 27;              // quotient bits produced
	localparam int CMP_W  = DIVD_W + QUO_W;  // width of a shifted divisor
	localparam int DIV_LAT = QUO_W + 1;      // divider latency in cycles

	typedef logic [DIVN_W-1:0] divn_t;
	typedef logic [DIVD_W-1:0] divd_t;
	typedef logic [QUO_W-1:0]  quo_t;
	typedef logic [CMP_W-1:0]  cmp_t;

	// Result field types.
	typedef logic signed [26:0] rate_t;
	typedef logic signed [20:0] spd_t;
	typedef logic signed [21:0] spd_sum_t;
	typedef logic signed [23:0] yaw_t;
	typedef logic signed [27:0] rad_t;

	// Fixed-point constants.
	localparam logic [29:0] PI_Q28     = 30'd843314857;
	localparam logic [9:0]  RATE_SCALE = 10'd1000;
	localparam quo_t RATE_MAX  = 27'd67108863;
	localparam quo_t SPEED_MAX = 27'd1000000;
	localparam quo_t YAW_MAX   = 27'd8000000;
	localparam quo_t RAD_MAX   = 27'd100000000;

	// Port widths.
	localparam int IN_W  = 88;
	localparam int OUT_W = 176;
	localparam int CFG_W = 16;

	// Drive modes.
	localparam logic [1:0] MODE_NEUTRAL = 2'd0;
	localparam logic [1:0] MODE_FWD     = 2'd1;
	localparam logic [1:0] MODE_REV     = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_PPR    = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_BASE   = 2'd2;

	// Direction of one item.
	typedef struct packed {
		logic zero;
		logic neg;
	} dir_t;

	// Data carried alongside the second divider pair.
	typedef struct packed {
		rate_t rl;
		rate_t rr;
		spd_t  sl;
		spd_t  sr;
		spd_t  mean;
		logic  yaw_neg;
		logic  rad_neg;
		logic  straight;
	} side_b_t;

endpackage

/* rtl/wheel_encoder_odometry.sv */
// ============================================================================
// wheel_encoder_odometry: differential-drive odometry from encoder frequencies
// Wheel rates and speeds, mean speed, yaw rate and turn radius in fixed point.
// ============================================================================
// Channel   Dir  Handshake                 Content
// s_*       in   s_tvalid / s_tready       one sample set per item
// m_*       out  m_tvalid / m_tready       one odometry result per item
// cfg_*     in   cfg_wr_en (no wait)       pulses/rev, radius, wheel base
//
// One item enters per cycle while the pipeline is not stalled; two 28-stage
// dividers lie in series (wheel rate/speed, then yaw rate/turn radius).
// Reset clears all valid bits and loads the register defaults.
// A stall on m_tready holds every stage; the pipeline moves whenever the
// output register is empty or being taken, and s_tready follows that.
// ============================================================================
module wheel_encoder_odometry (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// mode, freq_left_a, freq_left_b, freq_right_a, freq_right_b, body_speed
	input  logic [weo_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// rate_left, rate_right, speed_left, speed_right, mean_speed, yaw_rate,
	// turn_radius, straight
	output logic [weo_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [weo_pkg::CFG_W-1:0]   cfg_data
);

	logic        en;
	logic [15:0] ppr_q;
	logic [13:0] radius_q;
	logic [13:0] base_q;
	logic [15:0] ppr_eff;
	logic [13:0] base_eff;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q    <= 16'd1024;
			radius_q <= 14'd1650;
			base_q   <= 14'd600;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				weo_pkg::REG_PPR:    ppr_q    <= cfg_data;
				weo_pkg::REG_RADIUS: radius_q <= cfg_data[13:0];
				weo_pkg::REG_BASE:   base_q   <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// A zero divisor register acts as one.
	assign ppr_eff  = (ppr_q == '0) ? 16'd1 : ppr_q;
	assign base_eff = (base_q == '0) ? 14'd1 : base_q;

	// Global advance: the output register is empty or being taken.
	logic out_valid_q;
	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1: frequency sums and direction.
	logic          v_s1;
	logic [16:0]   sum_l_s1, sum_r_s1;
	weo_pkg::dir_t dir_s1;
	weo_pkg::dir_t dir_in;

	always_comb begin
		dir_in = '{zero: 1'b1, neg: 1'b0};
		case (s_tdata[1:0])
			weo_pkg::MODE_FWD:     dir_in = '{zero: 1'b0, neg: 1'b0};
			weo_pkg::MODE_REV:     dir_in = '{zero: 1'b0, neg: 1'b1};
			weo_pkg::MODE_NEUTRAL: dir_in = '{zero: (s_tdata[81:66] == '0), neg: 1'b0};
			default:               dir_in = '{zero: 1'b1, neg: 1'b0};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_l_s1 <= 17'(s_tdata[17:2]) + 17'(s_tdata[33:18]);
			sum_r_s1 <= 17'(s_tdata[49:34]) + 17'(s_tdata[65:50]);
			dir_s1   <= dir_in;
		end
	end

	// Stage 2: rate dividends and sum times radius.
	logic          v_s2;
	logic [27:0]   rnum_l_s2, rnum_r_s2;
	logic [30:0]   sr_l_s2, sr_r_s2;
	weo_pkg::dir_t dir_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			rnum_l_s2 <= 28'(sum_l_s1) * 28'(weo_pkg::RATE_SCALE) + 28'(ppr_eff);
			rnum_r_s2 <= 28'(sum_r_s1) * 28'(weo_pkg::RATE_SCALE) + 28'(ppr_eff);
			sr_l_s2   <= 31'(sum_l_s1) * 31'(radius_q);
			sr_r_s2   <= 31'(sum_r_s1) * 31'(radius_q);
			dir_s2    <= dir_s1;
		end
	end

	// Stage 3: multiply by pi and drop the Q28 fraction.
	logic          v_s3;
	logic [27:0]   rnum_l_s3, rnum_r_s3;
	logic [32:0]   n_l_s3, n_r_s3;
	logic [60:0]   pprod_l, pprod_r;
	weo_pkg::dir_t dir_s3;

	assign pprod_l = 61'(sr_l_s2) * 61'(weo_pkg::PI_Q28);
	assign pprod_r = 61'(sr_r_s2) * 61'(weo_pkg::PI_Q28);

	always_ff @(posedge clk) begin
		if (en) begin
			rnum_l_s3 <= rnum_l_s2;
			rnum_r_s3 <= rnum_r_s2;
			n_l_s3    <= pprod_l[60:28];
			n_r_s3    <= pprod_r[60:28];
			dir_s3    <= dir_s2;
		end
	end

	// First divider group: wheel rates and wheel speeds.
	weo_pkg::divd_t rate_den, spd_den;
	weo_pkg::divn_t spd_half;
	weo_pkg::quo_t  rq_l, rq_r, sq_l, sq_r;
	logic           ro_l, ro_r, so_l, so_r;

	assign rate_den = weo_pkg::divd_t'({ppr_eff, 1'b0});
	assign spd_den  = weo_pkg::divd_t'(ppr_eff) * weo_pkg::divd_t'(10);
	assign spd_half = weo_pkg::divn_t'(ppr_eff) * weo_pkg::divn_t'(5);

	weo_div u_div_rate_l (.clk(clk), .en(en), .num(weo_pkg::divn_t'(rnum_l_s3)),
		.den(rate_den), .quo(rq_l), .ovf(ro_l));
	weo_div u_div_rate_r (.clk(clk), .en(en), .num(weo_pkg::divn_t'(rnum_r_s3)),
		.den(rate_den), .quo(rq_r), .ovf(ro_r));
	weo_div u_div_spd_l (.clk(clk), .en(en), .num(weo_pkg::divn_t'(n_l_s3) + spd_half),
		.den(spd_den), .quo(sq_l), .ovf(so_l));
	weo_div u_div_spd_r (.clk(clk), .en(en), .num(weo_pkg::divn_t'(n_r_s3) + spd_half),
		.den(spd_den), .quo(sq_r), .ovf(so_r));

	// Direction and valid travel beside the first divider group.
	logic          va_s [0:weo_pkg::DIV_LAT-1];
	weo_pkg::dir_t dira_s [0:weo_pkg::DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			dira_s[0] <= dir_s3;
			for (int i = 1; i < weo_pkg::DIV_LAT; i++) dira_s[i] <= dira_s[i-1];
		end
	end

	// Stage B1: saturate and apply direction.
	logic          v_b1;
	weo_pkg::rate_t rl_b1, rr_b1;
	weo_pkg::spd_t  sl_b1, sr_b1;
	weo_pkg::rate_t rm_l, rm_r;
	weo_pkg::spd_t  sm_l, sm_r;
	weo_pkg::dir_t  dir_a;

	assign dir_a = dira_s[weo_pkg::DIV_LAT-1];
	assign rm_l = (ro_l || rq_l > weo_pkg::RATE_MAX) ? weo_pkg::rate_t'(weo_pkg::RATE_MAX)
		: weo_pkg::rate_t'(rq_l);
	assign rm_r = (ro_r || rq_r > weo_pkg::RATE_MAX) ? weo_pkg::rate_t'(weo_pkg::RATE_MAX)
		: weo_pkg::rate_t'(rq_r);
	assign sm_l = (so_l || sq_l > weo_pkg::SPEED_MAX) ? weo_pkg::spd_t'(weo_pkg::SPEED_MAX)
		: weo_pkg::spd_t'(sq_l);
	assign sm_r = (so_r || sq_r > weo_pkg::SPEED_MAX) ? weo_pkg::spd_t'(weo_pkg::SPEED_MAX)
		: weo_pkg::spd_t'(sq_r);

	always_ff @(posedge clk) begin
		if (en) begin
			rl_b1 <= dir_a.zero ? '0 : (dir_a.neg ? -rm_l : rm_l);
			rr_b1 <= dir_a.zero ? '0 : (dir_a.neg ? -rm_r : rm_r);
			sl_b1 <= dir_a.zero ? '0 : (dir_a.neg ? -sm_l : sm_l);
			sr_b1 <= dir_a.zero ? '0 : (dir_a.neg ? -sm_r : sm_r);
		end
	end

	// Stage B2: mean speed and operands of yaw rate and turn radius.
	logic              v_b2;
	weo_pkg::spd_sum_t ssum, sdiff;
	logic [20:0]       abs_sum, abs_diff, mean_mag;
	weo_pkg::divn_t    ynum_b2, rnum_b2;
	weo_pkg::divd_t    rden_b2;
	weo_pkg::side_b_t  side_b2;

	assign ssum     = weo_pkg::spd_sum_t'(sl_b1) + weo_pkg::spd_sum_t'(sr_b1);
	assign sdiff    = weo_pkg::spd_sum_t'(sr_b1) - weo_pkg::spd_sum_t'(sl_b1);
	assign abs_sum  = ssum[21] ? 21'(-ssum) : ssum[20:0];
	assign abs_diff = sdiff[21] ? 21'(-sdiff) : sdiff[20:0];
	assign mean_mag = 21'((22'(abs_sum) + 22'd1) >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			ynum_b2 <= weo_pkg::divn_t'(abs_diff) * weo_pkg::divn_t'(weo_pkg::RATE_SCALE)
				+ weo_pkg::divn_t'(base_eff >> 1);
			rnum_b2 <= weo_pkg::divn_t'(base_eff) * weo_pkg::divn_t'(abs_sum)
				+ weo_pkg::divn_t'(abs_diff >> 1);
			rden_b2 <= weo_pkg::divd_t'(abs_diff);
			side_b2.rl       <= rl_b1;
			side_b2.rr       <= rr_b1;
			side_b2.sl       <= sl_b1;
			side_b2.sr       <= sr_b1;
			side_b2.mean     <= ssum[21] ? -weo_pkg::spd_t'(mean_mag) : weo_pkg::spd_t'(mean_mag);
			side_b2.yaw_neg  <= sdiff[21];
			side_b2.rad_neg  <= ssum[21] ^ sdiff[21];
			side_b2.straight <= (sdiff == '0);
		end
	end

	// Second divider group: yaw rate and turn radius.
	weo_pkg::quo_t yq, radq;
	logic          yo, rado;

	weo_div u_div_yaw (.clk(clk), .en(en), .num(ynum_b2),
		.den(weo_pkg::divd_t'(base_eff)), .quo(yq), .ovf(yo));
	weo_div u_div_rad (.clk(clk), .en(en), .num(rnum_b2),
		.den(rden_b2), .quo(radq), .ovf(rado));

	logic             vb_s [0:weo_pkg::DIV_LAT-1];
	weo_pkg::side_b_t sideb_s [0:weo_pkg::DIV_LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			sideb_s[0] <= side_b2;
			for (int i = 1; i < weo_pkg::DIV_LAT; i++) sideb_s[i] <= sideb_s[i-1];
		end
	end

	// Output stage: saturate, sign and pack.
	weo_pkg::side_b_t sb;
	weo_pkg::yaw_t    yaw_mag;
	weo_pkg::rad_t    rad_mag;
	weo_pkg::side_b_t out_side_q;
	weo_pkg::yaw_t    yaw_q;
	weo_pkg::rad_t    rad_q;

	assign sb      = sideb_s[weo_pkg::DIV_LAT-1];
	assign yaw_mag = (yo || yq > weo_pkg::YAW_MAX) ? weo_pkg::yaw_t'(weo_pkg::YAW_MAX)
		: weo_pkg::yaw_t'(yq);
	assign rad_mag = (rado || radq > weo_pkg::RAD_MAX) ? weo_pkg::rad_t'(weo_pkg::RAD_MAX)
		: weo_pkg::rad_t'(radq);

	always_ff @(posedge clk) begin
		if (en) begin
			out_side_q <= sb;
			yaw_q      <= sb.yaw_neg ? -yaw_mag : yaw_mag;
			rad_q      <= sb.straight ? weo_pkg::rad_t'(weo_pkg::RAD_MAX)
				: (sb.rad_neg ? -rad_mag : rad_mag);
		end
	end

	// Valid bits for every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_b1        <= 1'b0;
			v_b2        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < weo_pkg::DIV_LAT; i++) begin
				va_s[i] <= 1'b0;
				vb_s[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1    <= s_tvalid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			va_s[0] <= v_s3;
			vb_s[0] <= v_b2;
			for (int i = 1; i < weo_pkg::DIV_LAT; i++) begin
				va_s[i] <= va_s[i-1];
				vb_s[i] <= vb_s[i-1];
			end
			v_b1        <= va_s[weo_pkg::DIV_LAT-1];
			v_b2        <= v_b1;
			out_valid_q <= vb_s[weo_pkg::DIV_LAT-1];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_side_q.straight, rad_q, yaw_q, out_side_q.mean,
		out_side_q.sr, out_side_q.sl, out_side_q.rr, out_side_q.rl};

endmodule

/* rtl/weo_div.sv */
// ============================================================================
// weo_div: pipelined unsigned restoring divider
// One quotient bit per stage; flags a quotient that does not fit in QUO_W bits.
// ============================================================================
module weo_div (
	input  logic           clk,
	input  logic           en,
	input  weo_pkg::divn_t num,
	input  weo_pkg::divd_t den,
	output weo_pkg::quo_t  quo,
	output logic           ovf
);

	weo_pkg::divn_t rem_s [0:weo_pkg::QUO_W];
	weo_pkg::divd_t den_s [0:weo_pkg::QUO_W];
	weo_pkg::quo_t  quo_s [0:weo_pkg::QUO_W];
	logic           ovf_s [0:weo_pkg::QUO_W];

	// Entry stage: capture operands and check for quotient overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= weo_pkg::cmp_t'(num) >= (weo_pkg::cmp_t'(den) << weo_pkg::QUO_W);
		end
	end

	// One trial subtraction per stage, most significant quotient bit first.
	for (genvar k = 1; k <= weo_pkg::QUO_W; k++) begin : g_step
		weo_pkg::cmp_t trial;
		logic          ge;

		assign trial = weo_pkg::cmp_t'(den_s[k-1]) << (weo_pkg::QUO_W - k);
		assign ge    = weo_pkg::cmp_t'(rem_s[k-1]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? rem_s[k-1] - trial[weo_pkg::DIVN_W-1:0] : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= quo_s[k-1] | (weo_pkg::quo_t'(ge) << (weo_pkg::QUO_W - k));
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[weo_pkg::QUO_W];
	assign ovf = ovf_s[weo_pkg::QUO_W];

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for the wheel encoder odometry block
// Sends encoder sample sets over the input stream and checks every odometry
// result against a predictor kept in the testbench. The run covers several
// register settings, random idling on both stream sides and a long output
// stall that backs up the pipeline.
// ============================================================================
module tb_top;

	localparam logic [1:0] MODE_STOP = 2'd3;
	localparam logic [1:0] REG_NONE  = 2'd3;
	localparam int SETTLE_CYC = 80;
	localparam int HOLD_CYC   = 400;
	localparam int PHASE_ITEMS = 380;
	localparam int EXP_DEPTH  = 2048;

	// One sample set.
	typedef struct {
		logic [1:0]  mode;
		logic [15:0] fla;
		logic [15:0] flb;
		logic [15:0] fra;
		logic [15:0] frb;
		logic [15:0] vspd;
	} sample_t;

	// One odometry result.
	typedef struct {
		weo_pkg::rate_t rl;
		weo_pkg::rate_t rr;
		weo_pkg::spd_t  sl;
		weo_pkg::spd_t  sr;
		weo_pkg::spd_t  mean;
		weo_pkg::yaw_t  yaw;
		weo_pkg::rad_t  rad;
		logic           straight;
	} odo_t;

	// Directed row: sample, and a typed result where one is given.
	typedef struct {
		sample_t smp;
		bit      typed;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [weo_pkg::IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [weo_pkg::OUT_W-1:0] m_tdata;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [weo_pkg::CFG_W-1:0] cfg_data;

	// Register copies used by the predictor.
	longint unsigned ppr_q;
	longint unsigned radius_q;
	longint unsigned base_q;

	// Expected results in send order; written at exp_wr, read at exp_rd.
	odo_t exp_mem [EXP_DEPTH];
	int exp_wr;
	int exp_rd;
	int errors;
	bit calm;
	bit hold_req;

	wheel_encoder_odometry u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Quotient rounded to nearest, halves away from zero.
	function automatic longint round_div(longint n, longint d);
		longint un, ud, q;
		bit neg;
		neg = (n < 0) != (d < 0);
		un = (n < 0) ? -n : n;
		ud = (d < 0) ? -d : d;
		q = (un + ud / 2) / ud;
		return neg ? -q : q;
	endfunction

	function automatic longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Rate and speed magnitudes of one wheel from its frequency sum.
	function automatic void wheel_mag(longint unsigned fsum, longint unsigned ppr,
			output longint rmag, output longint smag);
		longint unsigned den, s;
		rmag = clamp((fsum * 1000 + ppr) / (2 * ppr), 67108863);
		den = (ppr * 10) << 28;
		s = (fsum * radius_q * 64'd843314857 + den / 2) / den;
		smag = (s > 1000000) ? 1000000 : s;
	endfunction

	function automatic odo_t predict_odometry(sample_t smp);
		odo_t o;
		longint unsigned ppr;
		longint base, rl, rr, sl, sr;
		int sgn;
		ppr = (ppr_q == 0) ? 1 : ppr_q;
		base = (base_q == 0) ? 1 : base_q;
		if (smp.mode == weo_pkg::MODE_FWD) sgn = 1;
		else if (smp.mode == weo_pkg::MODE_REV) sgn = -1;
		else if (smp.mode == weo_pkg::MODE_NEUTRAL && smp.vspd != 0) sgn = 1;
		else sgn = 0;
		wheel_mag(longint'(smp.fla) + smp.flb, ppr, rl, sl);
		wheel_mag(longint'(smp.fra) + smp.frb, ppr, rr, sr);
		rl = sgn * rl; rr = sgn * rr; sl = sgn * sl; sr = sgn * sr;
		o.rl = weo_pkg::rate_t'(rl);
		o.rr = weo_pkg::rate_t'(rr);
		o.sl = weo_pkg::spd_t'(sl);
		o.sr = weo_pkg::spd_t'(sr);
		o.mean = weo_pkg::spd_t'(round_div(sl + sr, 2));
		o.yaw = weo_pkg::yaw_t'(clamp(round_div((sr - sl) * 1000, base), 8000000));
		if (sr == sl) begin
			o.straight = 1'b1;
			o.rad = weo_pkg::rad_t'(100000000);
		end else begin
			o.straight = 1'b0;
			o.rad = weo_pkg::rad_t'(clamp(round_div(base * (sr + sl), sr - sl), 100000000));
		end
		return o;
	endfunction

	// Result for a set with both wheels forced to zero.
	function automatic odo_t still_result();
		odo_t o;
		o.rl = '0; o.rr = '0; o.sl = '0; o.sr = '0; o.mean = '0; o.yaw = '0;
		o.rad = weo_pkg::rad_t'(100000000);
		o.straight = 1'b1;
		return o;
	endfunction

	function automatic sample_t mk(logic [1:0] m, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d, logic [15:0] v);
		sample_t s;
		s.mode = m; s.fla = a; s.flb = b; s.fra = c; s.frb = d; s.vspd = v;
		return s;
	endfunction

	function automatic logic [15:0] rand_freq();
		case ($urandom_range(0, 4))
			0: return 16'($urandom_range(0, 40));
			1: return 16'($urandom_range(0, 3000));
			2: return 16'($urandom_range(65000, 65535));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic sample_t rand_sample();
		sample_t s;
		s.mode = 2'($urandom_range(0, 3));
		s.fla = rand_freq();
		s.flb = rand_freq();
		s.fra = rand_freq();
		s.frb = rand_freq();
		// Equal sums on both wheels drive the straight case.
		if ($urandom_range(0, 7) == 0) begin
			s.fra = s.flb;
			s.frb = s.fla;
		end
		s.vspd = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom());
		return s;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			weo_pkg::REG_PPR:    ppr_q = val;
			weo_pkg::REG_RADIUS: radius_q = val & 16'h3FFF;
			weo_pkg::REG_BASE:   base_q = val & 16'h3FFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Offers one item and waits for it to be taken; expectation goes in on accept.
	task automatic send_item(sample_t smp, bit typed);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, smp.vspd, smp.frb, smp.fra, smp.flb, smp.fla, smp.mode};
		do @(posedge clk); while (!s_tready);
		exp_mem[exp_wr] = typed ? still_result() : predict_odometry(smp);
		exp_wr++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (exp_rd != exp_wr) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic chk(string name, longint e, longint a);
		if (e != a) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, e, a);
		end
	endtask

	// Output side: random ready bursts, a long hold on request, none when calm.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYC) @(posedge clk);
				hold_req = 1'b0;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat (calm ? 1 : $urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		odo_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.rl = m_tdata[26:0];
			got.rr = m_tdata[53:27];
			got.sl = m_tdata[74:54];
			got.sr = m_tdata[95:75];
			got.mean = m_tdata[116:96];
			got.yaw = m_tdata[140:117];
			got.rad = m_tdata[168:141];
			got.straight = m_tdata[169];
			if (exp_rd == exp_wr) begin
				errors++;
				$display("%0t: result with none expected, got rate_left %0d",
					$realtime, got.rl);
			end else begin
				want = exp_mem[exp_rd];
				exp_rd++;
				chk("rate_left", want.rl, got.rl);
				chk("rate_right", want.rr, got.rr);
				chk("speed_left", want.sl, got.sl);
				chk("speed_right", want.sr, got.sr);
				chk("mean_speed", want.mean, got.mean);
				chk("yaw_rate", want.yaw, got.yaw);
				chk("turn_radius", want.rad, got.rad);
				chk("straight", want.straight, got.straight);
			end
		end
	end

	// Main sequence.
	initial begin
		row_t rows [16];
		logic [15:0] ppr_set[4];
		logic [15:0] rad_set[4];
		logic [15:0] base_set[4];
		errors = 0;
		exp_wr = 0;
		exp_rd = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ppr_q = 1024;
		radius_q = 1650;
		base_q = 600;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		rows = '{
			'{mk(weo_pkg::MODE_NEUTRAL, 0, 0, 0, 0, 0), 1'b1},
			'{mk(MODE_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF), 1'b1},
			'{mk(weo_pkg::MODE_NEUTRAL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b1},
			'{mk(weo_pkg::MODE_FWD, 0, 0, 0, 0, 0), 1'b1},
			'{mk(weo_pkg::MODE_REV, 0, 0, 0, 0, 16'h8000), 1'b1},
			'{mk(weo_pkg::MODE_NEUTRAL, 1000, 2000, 500, 700, 16'h8000), 1'b0},
			'{mk(weo_pkg::MODE_NEUTRAL, 1000, 2000, 500, 700, 16'h0001), 1'b0},
			'{mk(weo_pkg::MODE_FWD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b0},
			'{mk(weo_pkg::MODE_REV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0), 1'b0},
			'{mk(weo_pkg::MODE_FWD, 16'hFFFF, 16'hFFFF, 0, 0, 0), 1'b0},
			'{mk(weo_pkg::MODE_REV, 0, 0, 16'hFFFF, 16'hFFFF, 0), 1'b0},
			'{mk(weo_pkg::MODE_FWD, 1, 0, 0, 0, 0), 1'b0},
			'{mk(weo_pkg::MODE_FWD, 300, 301, 301, 300, 16'h7FFF), 1'b0},
			'{mk(weo_pkg::MODE_REV, 5000, 5000, 5001, 5000, 16'hFFFF), 1'b0},
			'{mk(weo_pkg::MODE_FWD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555), 1'b0},
			'{mk(weo_pkg::MODE_REV, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA), 1'b0}
		};
		foreach (rows[i]) send_item(rows[i].smp, rows[i].typed);
		drain();

		// Random phases over several settings: minimum divisors, maximum,
		// zero divisors with an out-of-range radius, then typical values.
		ppr_set = '{16'd1, 16'hFFFF, 16'd0, 16'd0};
		rad_set = '{16'd10000, 16'd1, 16'hFFFF, 16'd0};
		base_set = '{16'd1, 16'd10000, 16'd0, 16'hFFFF};
		for (int ph = 0; ph < 5; ph++) begin
			if (ph < 4) begin
				write_reg(weo_pkg::REG_PPR,
					ph == 3 ? 16'($urandom_range(1, 4096)) : ppr_set[ph]);
				write_reg(weo_pkg::REG_RADIUS,
					ph == 3 ? 16'($urandom_range(1, 10000)) : rad_set[ph]);
				write_reg(weo_pkg::REG_BASE,
					ph == 3 ? 16'($urandom_range(1, 10000)) : base_set[ph]);
				write_reg(REG_NONE, 16'($urandom()));
			end
			if (ph == 1) hold_req = 1'b1;
			if (ph == 4) calm = 1'b1;
			repeat (PHASE_ITEMS) send_item(rand_sample(), 1'b0);
			drain();
		end

		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
